[rtl/core/pti_pkg.sv]
// Shared types and constants of the periodic trilinear interpolator.
`default_nettype none

package pti_pkg;

    // Sample, coordinate, weight and write-address widths.
    localparam int DATA_W    = 24;
    localparam int COORD_W   = 24;
    localparam int FRAC_W    = 16;
    localparam int WADDR_W   = 15;

    // Configuration port.
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
    localparam logic [CFG_W-1:0]     SIZE_RESET = 6'd32;

    // Operation carried on the input tuser.
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Input tdata layout, lowest field first, padded to whole bytes.
    localparam int OFS_WADDR  = 0;
    localparam int OFS_WVALUE = OFS_WADDR + WADDR_W;
    localparam int OFS_CX     = OFS_WVALUE + DATA_W;
    localparam int OFS_CY     = OFS_CX + COORD_W;
    localparam int OFS_CZ     = OFS_CY + COORD_W;
    localparam int IN_TDATA_W = 112;
    localparam int OUT_TDATA_W = 24;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic [FRAC_W-1:0]        t_weight;

    typedef struct packed {
        t_weight w_x;
        t_weight w_y;
        t_weight w_z;
    } t_weights;

    // One corner read on its way through the address pipeline.
    // idx bit 2 selects the upper x neighbor, bit 1 upper y, bit 0 upper z.
    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [2:0] idx;
    } t_corner_ctl;

endpackage

`default_nettype wire

[rtl/core/periodic_trilinear_interpolator.sv]
// Top level of the periodic trilinear interpolator: control, configuration and result path.
`default_nettype none

// The block keeps a periodic 3D grid of signed 24-bit samples in one single-port memory.
// Requests arrive on the s_axis channel; tuser selects the operation. A store request
// writes one sample. A query request carries three Q8.16 positions of which only the
// 16-bit fractions count, so positions wrap around the grid.
// A query walks the eight cell corners through a two-stage address pipeline and the
// memory, one corner per cycle, blending along z as the samples arrive, then y, then x.
// A query holds off every other request until its closing y and x blends are done and
// its result has moved to the output register; the eight reads on the single memory
// port plus the pipeline fill set how long that takes.
// The finished result sits in an output register, so new requests are taken while it
// waits; a stalled receiver only holds the block once a second result is ready.
// The user writes sizes on the always-ready cfg channel only while idle; it is unchecked.
// Reset (synchronous, active low) clears the control state and sets all three sizes to 32;
// grid contents are undefined until written and must be stored before they are queried.
module periodic_trilinear_interpolator
    import pti_pkg::*;
#(
    parameter int MAX_SIDE    = 32,
    parameter int GRID_POINTS = 32768
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Request channel.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: write_address[14:0], write_value[38:15], coord_x[62:39],
    //        coord_y[86:63], coord_z[110:87], zero pad[111]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: operation[0]
    input  wire logic                   s_axis_tuser,
    // Result channel.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: value[23:0]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // Configuration write channel.
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);

    localparam int SW  = $clog2(MAX_SIDE + 1);
    localparam int AW  = $clog2(GRID_POINTS);
    localparam int WXW = (AW > WADDR_W) ? AW : WADDR_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_Y    = 2'd1;
    localparam logic [1:0] TAIL_X    = 2'd2;

    // Corner codes: the first corner on the upper x side, and the last corner.
    localparam logic [2:0] CORNER_XH   = 3'd4;
    localparam logic [2:0] CORNER_LAST = 3'd7;

    logic [CFG_W-1:0]   r_size_x;
    logic [CFG_W-1:0]   r_size_y;
    logic [CFG_W-1:0]   r_size_z;
    logic [SW-1:0]      nx;
    logic [SW-1:0]      ny;
    logic [SW-1:0]      nz;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [1:0]         r_tail;
    logic [1:0]         n_tail;
    logic               r_out_valid;
    logic               n_out_valid;
    t_sample            r_out_data;

    logic               in_acc;
    logic               store_acc;
    logic               query_acc;
    logic               out_load;

    logic [WADDR_W-1:0] wa;
    logic [WXW-1:0]     wa_x;
    logic               wa_ok;
    t_sample            wvalue;

    t_weights           wts;
    t_corner_ctl        rd_ctl;
    logic [AW-1:0]      rd_addr;
    t_corner_ctl        r_s3;

    logic               mem_en;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    t_sample            mem_rdata;
    t_sample            rd_val;

    t_sample            r_even;
    t_sample            r_zc [4];
    t_sample            r_c0;
    t_sample            r_c1;
    t_sample            r_res;

    t_sample            bl_a;
    t_sample            bl_b;
    t_weight            bl_w;
    t_sample            bl_y;

    // A size of zero acts as one, and sizes above the grid limit are clamped.
    function automatic logic [SW-1:0] eff_size(input logic [CFG_W-1:0] r);
        logic [SW-1:0] e;
        priority if (r == '0) begin
            e = SW'(1);
        end else if (32'(r) > 32'(MAX_SIDE)) begin
            e = SW'(MAX_SIDE);
        end else begin
            e = SW'(r);
        end
        return e;
    endfunction

    assign nx = eff_size(r_size_x);
    assign ny = eff_size(r_size_y);
    assign nz = eff_size(r_size_z);

    // Configuration registers; writes to an index past the list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SIZE_X: r_size_x <= i_cfg_data;
                REG_SIZE_Y: r_size_y <= i_cfg_data;
                REG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Requests are taken only when no query is in flight.
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign store_acc     = in_acc && (s_axis_tuser == OP_STORE);
    assign query_acc     = in_acc && (s_axis_tuser == OP_QUERY);

    assign wa     = s_axis_tdata[OFS_WADDR +: WADDR_W];
    assign wa_x   = WXW'(wa);
    assign wa_ok  = 32'(wa) < 32'(GRID_POINTS);
    assign wvalue = s_axis_tdata[OFS_WVALUE +: DATA_W];

    pti_corner #(
        .MAX_SIDE    (MAX_SIDE),
        .GRID_POINTS (GRID_POINTS),
        .SW          (SW),
        .AW          (AW)
    ) u_corner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (query_acc),
        .i_frac_x (s_axis_tdata[OFS_CX +: FRAC_W]),
        .i_frac_y (s_axis_tdata[OFS_CY +: FRAC_W]),
        .i_frac_z (s_axis_tdata[OFS_CZ +: FRAC_W]),
        .i_nx     (nx),
        .i_ny     (ny),
        .i_nz     (nz),
        .o_wts    (wts),
        .o_ctl    (rd_ctl),
        .o_addr   (rd_addr)
    );

    // Stores and corner reads never overlap: stores are taken only while idle.
    assign mem_we   = store_acc && wa_ok;
    assign mem_en   = mem_we || rd_ctl.valid;
    assign mem_addr = store_acc ? wa_x[AW-1:0] : rd_addr;

    pti_grid #(
        .DEPTH (GRID_POINTS),
        .AW    (AW)
    ) u_grid (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (wvalue),
        .o_rdata (mem_rdata)
    );

    // A corner outside the grid reads as zero.
    assign rd_val = r_s3.zero ? '0 : mem_rdata;

    // One blend unit is shared. Odd corners finish a z pair; the y blend of the
    // lower x half slots in while the first upper-x corner arrives, and the
    // remaining y and x blends follow the last corner.
    always_comb begin
        bl_a = r_c0;
        bl_b = r_c1;
        bl_w = wts.w_x;
        priority if (r_s3.valid && r_s3.idx[0]) begin
            bl_a = r_even;
            bl_b = rd_val;
            bl_w = wts.w_z;
        end else if (r_s3.valid && (r_s3.idx == CORNER_XH)) begin
            bl_a = r_zc[0];
            bl_b = r_zc[1];
            bl_w = wts.w_y;
        end else if (r_tail == TAIL_Y) begin
            bl_a = r_zc[2];
            bl_b = r_zc[3];
            bl_w = wts.w_y;
        end else begin
            bl_a = r_c0;
            bl_b = r_c1;
            bl_w = wts.w_x;
        end
    end

    pti_blend u_blend (
        .i_a (bl_a),
        .i_b (bl_b),
        .i_w (bl_w),
        .o_y (bl_y)
    );

    always_ff @(posedge i_clk) begin
        if (r_s3.valid && !r_s3.idx[0]) begin
            r_even <= rd_val;
        end
        if (r_s3.valid && r_s3.idx[0]) begin
            r_zc[r_s3.idx[2:1]] <= bl_y;
        end
        if (r_s3.valid && (r_s3.idx == CORNER_XH)) begin
            r_c0 <= bl_y;
        end
        if (r_tail == TAIL_Y) begin
            r_c1 <= bl_y;
        end
        if (r_tail == TAIL_X) begin
            r_res <= bl_y;
        end
        if (out_load) begin
            r_out_data <= r_res;
        end
    end

    // Control: state, closing blend steps and the output register.
    assign out_load = (r_state == ST_HOLD) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state     = r_state;
        n_tail      = r_tail;
        n_out_valid = r_out_valid;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (query_acc) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_s3.valid && (r_s3.idx == CORNER_LAST)) begin
                    n_tail = TAIL_Y;
                end else if (r_tail == TAIL_Y) begin
                    n_tail = TAIL_X;
                end else if (r_tail == TAIL_X) begin
                    n_tail  = TAIL_NONE;
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tail      <= TAIL_NONE;
            r_out_valid <= 1'b0;
            r_s3        <= '0;
        end else begin
            r_state     <= n_state;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
            r_s3        <= rd_ctl;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

[rtl/core/pti_grid.sv]
// Single-port grid sample memory with a registered read.
`default_nettype none

module pti_grid
    import pti_pkg::*;
#(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire t_sample       i_wdata,
    output t_sample            o_rdata
);

    t_sample r_mem [DEPTH];
    t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/pti_blend.sv]
// Linear blend of two samples with a 16-bit weight, rounded toward minus infinity.
`default_nettype none

module pti_blend
    import pti_pkg::*;
(
    input  wire t_sample i_a,
    input  wire t_sample i_b,
    input  wire t_weight i_w,
    output t_sample      o_y
);

    // a*(1-w) + b*w equals a + (b-a)*w, so one multiplier does the step.
    logic signed [DATA_W:0]              diff;
    logic signed [FRAC_W:0]              w_s;
    logic signed [DATA_W+FRAC_W+1:0]     prod;

    assign diff = (DATA_W+1)'(i_b) - (DATA_W+1)'(i_a);
    assign w_s  = $signed({1'b0, i_w});
    assign prod = diff * w_s;
    assign o_y  = i_a + $signed(prod[FRAC_W +: DATA_W]);

endmodule

`default_nettype wire

[rtl/core/pti_corner.sv]
// Axis split and the corner address pipeline that walks the eight grid corners.
`default_nettype none

module pti_corner
    import pti_pkg::*;
#(
    parameter int MAX_SIDE    = 32,
    parameter int GRID_POINTS = 32768,
    parameter int SW          = 6,
    parameter int AW          = 15
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic [FRAC_W-1:0] i_frac_x,
    input  wire logic [FRAC_W-1:0] i_frac_y,
    input  wire logic [FRAC_W-1:0] i_frac_z,
    input  wire logic [SW-1:0]     i_nx,
    input  wire logic [SW-1:0]     i_ny,
    input  wire logic [SW-1:0]     i_nz,
    output t_weights               o_wts,
    output t_corner_ctl            o_ctl,
    output logic [AW-1:0]          o_addr
);

    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;
    localparam int PW   = FRAC_W + SW;
    localparam int TW   = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int S2W  = SW + TW + 1;
    localparam int XW   = (S2W > AW) ? S2W : AW;

    logic [FRAC_W-1:0] frac [3];
    logic [SW-1:0]     n    [3];
    logic [PW-1:0]     p    [3];
    logic [SW:0]       inc  [3];

    logic [SW-1:0]     r_lo [3];
    logic [SW-1:0]     r_hi [3];
    t_weight           r_w  [3];

    logic              r_issue;
    logic [2:0]        r_cnt;

    logic [SW-1:0]     ix;
    logic [SW-1:0]     iy;
    logic [SW-1:0]     iz;
    logic [2*SW-1:0]   prod1;
    logic [2*SW:0]     sum1;

    logic              r_v1;
    logic [2:0]        r_idx1;
    logic [TW-1:0]     r_t;
    logic [SW-1:0]     r_iz1;

    logic [SW+TW-1:0]  prod2;
    logic [S2W-1:0]    sum2;
    logic [XW-1:0]     sum2_x;

    logic              r_v2;
    logic              r_zero2;
    logic [2:0]        r_idx2;
    logic [AW-1:0]     r_addr;

    assign frac[AX_X] = i_frac_x;
    assign frac[AX_Y] = i_frac_y;
    assign frac[AX_Z] = i_frac_z;
    assign n[AX_X]    = i_nx;
    assign n[AX_Y]    = i_ny;
    assign n[AX_Z]    = i_nz;

    // The fraction times the axis size: upper bits give the cell, lower bits the weight.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign p[a]   = PW'(frac[a]) * PW'(n[a]);
        assign inc[a] = (SW+1)'(p[a][FRAC_W +: SW]) + (SW+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= p[a][FRAC_W +: SW];
                r_w[a]  <= p[a][FRAC_W-1:0];
                r_hi[a] <= (inc[a] >= {1'b0, n[a]}) ? '0 : inc[a][SW-1:0];
            end
        end
    end

    assign o_wts = '{w_x: r_w[AX_X], w_y: r_w[AX_Y], w_z: r_w[AX_Z]};

    // Corner counter: one corner enters the pipeline each cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_cnt   <= '0;
        end else if (i_load) begin
            r_issue <= 1'b1;
            r_cnt   <= '0;
        end else if (r_issue) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                r_issue <= 1'b0;
            end
        end
    end

    // Stage one: row index y + ny*x.
    assign ix    = r_cnt[2] ? r_hi[AX_X] : r_lo[AX_X];
    assign iy    = r_cnt[1] ? r_hi[AX_Y] : r_lo[AX_Y];
    assign iz    = r_cnt[0] ? r_hi[AX_Z] : r_lo[AX_Z];
    assign prod1 = i_ny * ix;
    assign sum1  = (2*SW+1)'(prod1) + (2*SW+1)'(iy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_cnt;
        r_t    <= sum1[TW-1:0];
        r_iz1  <= iz;
    end

    // Stage two: linear index z + nz*row and the range check.
    assign prod2  = (SW+TW)'(i_nz) * (SW+TW)'(r_t);
    assign sum2   = S2W'(prod2) + S2W'(r_iz1);
    assign sum2_x = XW'(sum2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx2  <= r_idx1;
        r_zero2 <= 32'(sum2) >= 32'(GRID_POINTS);
        r_addr  <= sum2_x[AW-1:0];
    end

    assign o_ctl  = '{valid: r_v2, zero: r_zero2, idx: r_idx2};
    assign o_addr = r_addr;

endmodule

`default_nettype wire

[sim/periodic_trilinear_interpolator_test.sv]
// Self-checking testbench for the periodic trilinear interpolator: stores, queries and sizes.
`timescale 1ns / 100ps

module periodic_trilinear_interpolator_test;
    import pti_pkg::*;

    localparam int MAX_SIDE        = 32;
    localparam int GRID_POINTS     = 32768;
    // Extra margin that wait_idle adds after the last answer, before a size write.
    localparam int SETTLE_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PHASE_COUNT     = 8;
    localparam int PHASE_REQUESTS  = 210;
    localparam int MAX_GAP         = 40;
    localparam int DIRECTED_ROWS   = 24;

    // Index 3 of the configuration port names no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam t_sample SAMPLE_MAX = 24'sh7FFFFF;
    localparam t_sample SAMPLE_MIN = 24'sh800000;

    typedef enum logic [1:0] {
        ROW_STORE,
        ROW_QUERY,
        ROW_SIZES
    } t_row_kind;

    // One line of the directed table. A size row carries size_x, size_y and size_z in the
    // low bits of the three coordinate fields. When known is set the answer is typed in.
    typedef struct packed {
        t_row_kind            kind;
        logic [WADDR_W-1:0]   addr;
        t_sample              data;
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        logic [COORD_W-1:0]   cz;
        logic                 known;
        t_sample              answer;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = OP_STORE;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = REG_SIZE_X;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    // Mirror of the block: the grid contents, which entries hold a sample, and the sizes.
    t_sample          grid_model [GRID_POINTS];
    bit               grid_written [GRID_POINTS];
    logic [CFG_W-1:0] size_reg [3];

    // Interpolated values still owed by the block, oldest first.
    t_sample pending_values [$];
    t_sample oldest_value;

    int error_count = 0;
    int requests_sent = 0;
    int quiet_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    t_row directed_rows [DIRECTED_ROWS] = '{
        // Reset sizes of 32. Fraction zero gives weight zero, so only the lower corner counts.
        '{ROW_STORE, 15'd0,     SAMPLE_MIN, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b0, 24'sd0},
        '{ROW_QUERY, 15'h7FFF,  SAMPLE_MAX, 24'h000000, 24'h000000, 24'h000000, 1'b1, SAMPLE_MIN},
        '{ROW_QUERY, 15'd0,     24'sd0,     24'h800000, 24'h800000, 24'h800000, 1'b1, SAMPLE_MIN},
        // The integer part of a position is dropped.
        '{ROW_QUERY, 15'd0,     24'sd0,     24'h010000, 24'h7F0000, 24'hFF0000, 1'b1, SAMPLE_MIN},
        '{ROW_STORE, 15'h7FFF,  SAMPLE_MAX, 24'h000000, 24'hFFFFFF, 24'h000000, 1'b0, 24'sd0},
        // Largest fractions land in the last cell, whose upper neighbor wraps to zero.
        '{ROW_QUERY, 15'd0,     24'sd0,     24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 24'sd0},
        '{ROW_QUERY, 15'd0,     24'sd0,     24'h00FFFF, 24'hFFFFFF, 24'h00FFFF, 1'b0, 24'sd0},
        // A one-point grid: every corner is entry zero and blending must return it unchanged.
        '{ROW_SIZES, 15'd0,     24'sd0,     24'd1,      24'd1,      24'd1,      1'b0, 24'sd0},
        '{ROW_STORE, 15'd0,     SAMPLE_MAX, 24'h000000, 24'h000000, 24'h000000, 1'b0, 24'sd0},
        '{ROW_QUERY, 15'd0,     24'sd0,     24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, SAMPLE_MAX},
        '{ROW_QUERY, 15'h5555,  24'sh2AAAAA, 24'h123456, 24'hABCDEF, 24'h5A5A5A, 1'b1, SAMPLE_MAX},
        // A size of zero behaves as one.
        '{ROW_SIZES, 15'd0,     24'sd0,     24'd0,      24'd0,      24'd0,      1'b0, 24'sd0},
        '{ROW_STORE, 15'd0,     SAMPLE_MIN, 24'h000000, 24'h000000, 24'h000000, 1'b0, 24'sd0},
        '{ROW_QUERY, 15'd0,     24'sd0,     24'h00C000, 24'h80C000, 24'hFFC000, 1'b1, SAMPLE_MIN},
        // A size above the maximum behaves as 32: half a turn lands on cell 16 with no weight.
        '{ROW_SIZES, 15'd0,     24'sd0,     24'd63,     24'd63,     24'd63,     1'b0, 24'sd0},
        '{ROW_STORE, 15'd16912, 24'sd4660,  24'h000000, 24'h000000, 24'h000000, 1'b0, 24'sd0},
        '{ROW_QUERY, 15'd0,     24'sd0,     24'h008000, 24'h008000, 24'h008000, 1'b1, 24'sd4660},
        // Blending between the two extremes exercises rounding toward minus infinity.
        '{ROW_SIZES, 15'd0,     24'sd0,     24'd2,      24'd2,      24'd2,      1'b0, 24'sd0},
        '{ROW_STORE, 15'd0,     SAMPLE_MAX, 24'h000000, 24'h000000, 24'h000000, 1'b0, 24'sd0},
        '{ROW_STORE, 15'd1,     SAMPLE_MIN, 24'h000000, 24'h000000, 24'h000000, 1'b0, 24'sd0},
        '{ROW_QUERY, 15'd0,     24'sd0,     24'h000000, 24'h000000, 24'h004000, 1'b0, 24'sd0},
        '{ROW_QUERY, 15'd0,     24'sd0,     24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 24'sd0},
        // Unequal axes check the order of the linear index.
        '{ROW_SIZES, 15'd0,     24'sd0,     24'd3,      24'd5,      24'd7,      1'b0, 24'sd0},
        '{ROW_QUERY, 15'd0,     24'sd0,     24'h2AAAAA, 24'h555555, 24'h3C3C3C, 1'b0, 24'sd0}
    };

    periodic_trilinear_interpolator #(
        .MAX_SIDE    (MAX_SIDE),
        .GRID_POINTS (GRID_POINTS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The receiver drops tready at random, at the rate set for the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Effective size of one axis: zero counts as one and anything above the maximum is clipped.
    function automatic int unsigned side(input int axis);
        logic [CFG_W-1:0] r;
        r = size_reg[axis];
        if (r == 0) return 1;
        if (r > MAX_SIDE) return MAX_SIDE;
        return r;
    endfunction

    // Splits a position into its lower cell, the wrapped upper cell and the Q0.16 weight.
    function automatic void split_coord(input logic [COORD_W-1:0] c, input int unsigned n,
                                        output int unsigned lo, output int unsigned hi,
                                        output int unsigned w);
        int unsigned p;
        p = c[FRAC_W-1:0] * n;
        lo = p >> FRAC_W;
        w = p & 32'hFFFF;
        hi = lo + 1;
        if (hi >= n) hi = 0;
    endfunction

    function automatic int unsigned grid_index(input int unsigned ix, input int unsigned iy,
                                               input int unsigned iz);
        return iz + side(2) * (iy + side(1) * ix);
    endfunction

    function automatic t_sample corner_sample(input int unsigned ix, input int unsigned iy,
                                              input int unsigned iz);
        int unsigned addr;
        addr = grid_index(ix, iy, iz);
        if (addr >= GRID_POINTS) return '0;
        return grid_model[addr];
    endfunction

    // floor((a*(1-w) + b*w)), with w in 1/65536 steps.
    function automatic t_sample mix(input t_sample a, input t_sample b, input int unsigned w);
        longint acc;
        longint shifted;
        acc = longint'(a) * (64'sd65536 - longint'(w)) + longint'(b) * longint'(w);
        shifted = acc >>> FRAC_W;
        return shifted[DATA_W-1:0];
    endfunction

    // Expected answer of a query against the current grid and sizes: z first, then y, then x.
    function automatic t_sample interpolate_at(input logic [COORD_W-1:0] cx,
                                               input logic [COORD_W-1:0] cy,
                                               input logic [COORD_W-1:0] cz);
        int unsigned xl, xh, wx, yl, yh, wy, zl, zh, wz;
        t_sample c00, c01, c10, c11, c0, c1;
        split_coord(cx, side(0), xl, xh, wx);
        split_coord(cy, side(1), yl, yh, wy);
        split_coord(cz, side(2), zl, zh, wz);
        c00 = mix(corner_sample(xl, yl, zl), corner_sample(xl, yl, zh), wz);
        c01 = mix(corner_sample(xl, yh, zl), corner_sample(xl, yh, zh), wz);
        c10 = mix(corner_sample(xh, yl, zl), corner_sample(xh, yl, zh), wz);
        c11 = mix(corner_sample(xh, yh, zl), corner_sample(xh, yh, zh), wz);
        c0 = mix(c00, c01, wy);
        c1 = mix(c10, c11, wy);
        return mix(c0, c1, wx);
    endfunction

    // Random position, with whole-cell fractions and the largest fraction mixed in.
    function automatic logic [COORD_W-1:0] pick_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return {r[7:0], 16'h0000};
            1: return {r[7:0], 16'hFFFF};
            default: return r[COORD_W-1:0];
        endcase
    endfunction

    function automatic t_sample pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return -24'sd1;
            default: return r[DATA_W-1:0];
        endcase
    endfunction

    // Presents one request and returns at the edge where it is taken, with tvalid still high
    // so that a following request can go out without a gap. The mirror is updated at that
    // edge, so a query sees exactly the stores taken before it.
    task automatic push_request(input logic op, input logic [WADDR_W-1:0] addr,
                                input t_sample data, input logic [COORD_W-1:0] cx,
                                input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz,
                                input logic known, input t_sample answer);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, cz, cy, cx, data, addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        requests_sent++;
        if (op == OP_STORE) begin
            grid_model[addr] = data;
            grid_written[addr] = 1'b1;
        end else begin
            pending_values.push_back(known ? answer : interpolate_at(cx, cy, cz));
        end
    endtask

    // Stores a random sample in every corner of the coming query that was never written,
    // so that the block never reads an undefined entry.
    task automatic fill_corners(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                                input logic [COORD_W-1:0] cz);
        int unsigned xs [2];
        int unsigned ys [2];
        int unsigned zs [2];
        int unsigned w;
        int unsigned addr;
        split_coord(cx, side(0), xs[0], xs[1], w);
        split_coord(cy, side(1), ys[0], ys[1], w);
        split_coord(cz, side(2), zs[0], zs[1], w);
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                for (int k = 0; k < 2; k++) begin
                    addr = grid_index(xs[i], ys[j], zs[k]);
                    if (!grid_written[addr]) begin
                        push_request(OP_STORE, addr[WADDR_W-1:0], pick_sample(), pick_coord(),
                                     pick_coord(), pick_coord(), 1'b0, '0);
                    end
                end
            end
        end
    endtask

    // Holds off new requests until every answer is back, then lets any store in flight finish.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three sizes back to back once the block is idle; the spare index can follow.
    task automatic change_sizes(input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sy,
                                input logic [CFG_W-1:0] sz, input bit poke_spare);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_W-1:0]     val [4];
        logic [31:0]          r;
        int                   count;
        wait_idle();
        r = $urandom;
        idx[0] = REG_SIZE_X;
        idx[1] = REG_SIZE_Y;
        idx[2] = REG_SIZE_Z;
        idx[3] = REG_SPARE;
        val[0] = sx;
        val[1] = sy;
        val[2] = sz;
        val[3] = r[CFG_W-1:0];
        count = poke_spare ? 4 : 3;
        for (int k = 0; k < count; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            if (idx[k] != REG_SPARE) size_reg[idx[k]] = val[k];
        end
        i_cfg_valid <= 1'b0;
    endtask

    // One random step. Most steps are queries preceded by the stores their corners need;
    // the rest are stores inside the current grid, stores anywhere, or a full drain.
    task automatic random_step();
        logic [31:0]        r;
        logic [31:0]        s;
        logic [COORD_W-1:0] cx, cy, cz;
        int unsigned        span;
        int                 pick;
        r = $urandom;
        s = $urandom;
        pick = $urandom_range(99);
        if (pick < 2) begin
            wait_idle();
        end else if (pick < 62) begin
            cx = pick_coord();
            cy = pick_coord();
            cz = pick_coord();
            fill_corners(cx, cy, cz);
            push_request(OP_QUERY, r[WADDR_W-1:0], s[DATA_W-1:0], cx, cy, cz, 1'b0, '0);
        end else if (pick < 85) begin
            span = side(0) * side(1) * side(2);
            r = $urandom_range(span - 1);
            push_request(OP_STORE, r[WADDR_W-1:0], pick_sample(), pick_coord(), pick_coord(),
                         pick_coord(), 1'b0, '0);
        end else begin
            push_request(OP_STORE, r[WADDR_W-1:0], s[DATA_W-1:0], pick_coord(), pick_coord(),
                         pick_coord(), 1'b0, '0);
        end
    endtask

    // Every answer taken from the block is checked against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_values.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, got %0d",
                         $time, $signed(m_axis_tdata[DATA_W-1:0]));
            end else begin
                oldest_value = pending_values.pop_front();
                if (m_axis_tdata[DATA_W-1:0] !== oldest_value) begin
                    error_count++;
                    $display("%0t: value mismatch, expected %0d, got %0d",
                             $time, oldest_value, $signed(m_axis_tdata[DATA_W-1:0]));
                end
            end
        end
    end

    // Ends the run when no request, answer or size write has moved for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("periodic_trilinear_interpolator_test NOT OK");
            $finish;
        end
    end

    initial begin
        logic [31:0]      r;
        logic [CFG_W-1:0] sx, sy, sz;
        int               phase_end;

        size_reg[REG_SIZE_X] = SIZE_RESET;
        size_reg[REG_SIZE_Y] = SIZE_RESET;
        size_reg[REG_SIZE_Z] = SIZE_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run without any idling.
        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            case (directed_rows[n].kind)
                ROW_SIZES: begin
                    change_sizes(directed_rows[n].cx[CFG_W-1:0],
                                 directed_rows[n].cy[CFG_W-1:0],
                                 directed_rows[n].cz[CFG_W-1:0], 1'b0);
                end
                ROW_QUERY: begin
                    fill_corners(directed_rows[n].cx, directed_rows[n].cy,
                                 directed_rows[n].cz);
                    push_request(OP_QUERY, directed_rows[n].addr, directed_rows[n].data,
                                 directed_rows[n].cx, directed_rows[n].cy,
                                 directed_rows[n].cz, directed_rows[n].known,
                                 directed_rows[n].answer);
                end
                default: begin
                    push_request(OP_STORE, directed_rows[n].addr, directed_rows[n].data,
                                 directed_rows[n].cx, directed_rows[n].cy,
                                 directed_rows[n].cz, 1'b0, '0);
                end
            endcase
        end

        // Random part. Each phase gets its own sizes, the extremes among them, and one of
        // four idling patterns, so every pattern is seen twice.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            r = $urandom;
            case (phase)
                0: begin sx = 6'd32; sy = 6'd32; sz = 6'd32; end
                1: begin sx = 6'd1;  sy = 6'd1;  sz = 6'd1;  end
                2: begin sx = 6'd0;  sy = 6'd63; sz = 6'd33; end
                3: begin sx = 6'd2;  sy = 6'd3;  sz = 6'd5;  end
                4: begin sx = 6'd63; sy = 6'd1;  sz = 6'd0;  end
                5: begin
                    sx = 6'($urandom_range(32, 1));
                    sy = 6'($urandom_range(32, 1));
                    sz = 6'($urandom_range(32, 1));
                end
                6: begin sx = r[5:0]; sy = r[13:8]; sz = r[21:16]; end
                default: begin sx = 6'd4; sy = 6'd4; sz = 6'd4; end
            endcase
            change_sizes(sx, sy, sz, phase == 2);
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
                default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
            endcase
            phase_end = requests_sent + PHASE_REQUESTS;
            while (requests_sent < phase_end) random_step();
        end

        wait_idle();
        if (error_count == 0) begin
            $display("periodic_trilinear_interpolator_test OK");
        end else begin
            $display("periodic_trilinear_interpolator_test NOT OK");
        end
        $finish;
    end

endmodule
